// File: rtl/core/fsp2_pkg.sv
// shared constants, types and helper functions for the power-of-two scaling unit
package fsp2_pkg;

  localparam logic [31:0] SgnMask    = 32'h8000_0000;
  localparam logic [31:0] MagMask    = 32'h7fff_ffff;
  localparam logic [31:0] InfBits    = 32'h7f80_0000;
  localparam logic [31:0] QnanBits   = 32'h7fc0_0000;
  localparam logic [31:0] BigIntBits = 32'h4b00_0000;
  localparam logic [31:0] OneBits    = 32'h3f80_0000;
  localparam logic [16:0] ClampCount = 17'd65000;
  localparam logic [7:0]  FracBias   = 8'h96;

  // signed scale count, wide enough for any integral |y| below 2^23 plus the
  // biased exponent of x
  typedef logic signed [24:0] count_t;

  // decoded operand pair, handed from the decode stage to the scale stage
  typedef struct packed {
    logic        special;   // result fully known, no scaling needed
    logic [31:0] fixed_res;
    logic [31:0] x;
    count_t      n;
  } dec_t;

  // count of leading zeros of a 23-bit fraction, 0..23
  function automatic logic [4:0] lzc23(input logic [22:0] v);
    logic [4:0] c;
    logic       hit;
    c   = 5'd23;
    hit = 1'b0;
    for (int i = 22; i >= 0; i--) begin
      if (!hit && v[i]) begin
        c   = 5'(22 - i);
        hit = 1'b1;
      end
    end
    return c;
  endfunction

endpackage

// File: rtl/core/float_scale_by_power_of_two_unit.sv
// top level of the single-precision scale-by-power-of-two unit
// usage:
//   input channel carries x_bits and y_bits (ieee single patterns) with
//   in_valid / in_stall; a transfer happens when in_valid is high and
//   in_stall is low. the result channel carries result_bits with
//   out_valid / out_stall, transfer on out_valid high and out_stall low.
//   result is x * 2^y with nearest-even rounding, overflow to infinity,
//   gradual underflow and canonical nan 0x7fc00000.
// path: each input passes the operand register, then the result register.
// throughput: one item per cycle while the result channel is not stalled,
//   set by the single decode + scale pass between the two registers.
// stall: result register loads only when empty or taken; operand register
//   loads when empty or when the result loads. a stalled receiver holds
//   result_bits steady; back-pressure reaches in_stall in the same cycle.
// reset: rst (synchronous) empties both stages; no results are pending.
module float_scale_by_power_of_two_unit
  import fsp2_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] x_bits,
  input  logic [31:0] y_bits,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] result_bits
);

  // operand stage
  logic        op_valid;
  logic [31:0] op_x, op_y;
  dec_t        dec;
  logic [31:0] res_next;
  logic        advance;

  // result stage moves when it is empty or its content is taken
  assign advance  = !out_valid || !out_stall;
  assign in_stall = op_valid && !advance;

  fsp2_decode u_decode (
    .x_bits (op_x),
    .y_bits (op_y),
    .dec    (dec)
  );

  fsp2_scale u_scale (
    .dec         (dec),
    .result_bits (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      op_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        out_valid <= op_valid;
        if (op_valid)
          result_bits <= res_next;
      end
      if (!in_stall) begin
        op_valid <= in_valid;
        if (in_valid) begin
          op_x <= x_bits;
          op_y <= y_bits;
        end
      end
    end
  end

endmodule

// File: rtl/core/fsp2_decode.sv
// operand classification and exponent extraction from y
module fsp2_decode
  import fsp2_pkg::*;
(
  input  logic [31:0] x_bits,
  input  logic [31:0] y_bits,
  output dec_t        dec
);

  logic [31:0] hx, hy;
  logic        yneg;
  logic [7:0]  k;
  logic [23:0] mant;
  logic [31:0] fmask;
  logic [23:0] ival;

  assign hx   = x_bits & MagMask;
  assign hy   = y_bits & MagMask;
  assign yneg = y_bits[31];
  // k only meaningful for 1 <= |y| < 2^23, where it lies in 1..23
  assign k    = FracBias - hy[30:23];
  assign mant = {1'b1, hy[22:0]};
  assign fmask = (32'd1 << k[4:0]) - 32'd1;
  assign ival = mant >> k[4:0];

  always_comb begin
    dec.special   = 1'b0;
    dec.fixed_res = x_bits;
    dec.x         = x_bits;
    dec.n         = '0;
    if (hx > InfBits || hy >= InfBits) begin
      dec.special = 1'b1;
      if (hx > InfBits || hy > InfBits)
        dec.fixed_res = QnanBits;
      else if (!yneg)
        dec.fixed_res = (hx == 32'd0) ? QnanBits : ((x_bits & SgnMask) | InfBits);
      else
        dec.fixed_res = (hx == InfBits) ? QnanBits : (x_bits & SgnMask);
    end else if (hy >= BigIntBits) begin
      dec.n = yneg ? -count_t'(ClampCount) : count_t'(ClampCount);
    end else if (hy < OneBits) begin
      dec.special   = 1'b1;
      dec.fixed_res = (hy == 32'd0) ? x_bits : QnanBits;
    end else if ((hy & fmask) != 32'd0) begin
      dec.special   = 1'b1;
      dec.fixed_res = QnanBits;
    end else begin
      dec.n = yneg ? -count_t'(ival) : count_t'(ival);
    end
  end

endmodule

// File: rtl/core/fsp2_scale.sv
// exponent adjust with overflow, gradual underflow and nearest-even rounding
module fsp2_scale
  import fsp2_pkg::*;
(
  input  dec_t        dec,
  output logic [31:0] result_bits
);

  logic [31:0] sign, mag;
  logic [22:0] frac;
  logic [4:0]  lz;
  logic [23:0] sig;
  count_t      be0, be;
  logic [4:0]  sh;
  logic [23:0] rem, half, q, mask;

  assign sign = dec.x & SgnMask;
  assign mag  = dec.x & MagMask;
  assign frac = mag[22:0];
  assign lz   = lzc23(frac);

  always_comb begin
    if (mag[30:23] == 8'd0) begin
      // subnormal input: normalize so bit 23 is set
      sig = {1'b0, frac} << (lz + 5'd1);
      be0 = -count_t'(lz);
    end else begin
      sig = {1'b1, frac};
      be0 = count_t'(mag[30:23]);
    end
  end

  assign be = be0 + dec.n;
  // shift only used when 1-be is 1..24; larger shifts always round to zero
  assign sh   = 5'(count_t'(1) - be);
  assign mask = (24'd1 << sh) - 24'd1;
  assign rem  = sig & mask;
  assign half = 24'd1 << (sh - 5'd1);
  assign q    = sig >> sh;

  always_comb begin
    if (dec.special)
      result_bits = dec.fixed_res;
    else if (mag == 32'd0 || mag == InfBits)
      result_bits = dec.x;
    else if (be >= count_t'(255))
      result_bits = sign | InfBits;
    else if (be >= count_t'(1))
      result_bits = sign | {1'b0, be[7:0], sig[22:0]};
    else if (be < count_t'(-23))
      result_bits = sign;
    else if (rem > half || (rem == half && q[0]))
      result_bits = sign | {8'd0, q + 24'd1};
    else
      result_bits = sign | {8'd0, q};
  end

endmodule
